// File: hw/rtl/circular_double_ended_queue_macros.svh
// Assertion macros shared by the queue RTL. Each property is sampled on the
// rising edge of clk and is switched off while arst_n is low.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define CDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CDQ_ASSERT_NEVER(lbl, expr, msg) \
	`CDQ_ASSERT(lbl, !(expr), msg)
`else
`define CDQ_ASSERT(lbl, prop, msg)
`define CDQ_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: hw/rtl/cdq_pkg.sv
package cdq_pkg;
	localparam int CMD_W     = 3;
	localparam int KEY_W     = 32;
	localparam int CAP_W     = 5;
	localparam int CAP_RESET = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_PEEK       = 3'd4
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;
endpackage

// File: hw/rtl/cdq_if.sv
interface cdq_cmd_if;
	logic                              valid;
	logic                              ready;
	logic        [cdq_pkg::CMD_W-1:0]  command;
	logic signed [cdq_pkg::KEY_W-1:0]  key;

	modport source (output valid, command, key, input ready);
	modport sink (input valid, command, key, output ready);
endinterface

interface cdq_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [cdq_pkg::KEY_W-1:0]  front_value;
	logic signed [cdq_pkg::KEY_W-1:0]  rear_value;
	logic                              is_empty;
	logic                              is_full;
	logic                              rejected;

	modport source (output valid, front_value, rear_value, is_empty, is_full, rejected,
		input ready);
	modport sink (input valid, front_value, rear_value, is_empty, is_full, rejected,
		output ready);
endinterface

// File: hw/rtl/cdq_ram.sv
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/circular_double_ended_queue.sv
// Double-ended queue of up to DEPTH entries held in a single RAM with a
// registered read port. Inserts, peeks, rejected commands and a delete that
// empties the queue need no RAM read; a delete that leaves entries behind
// passes through the read state, as the new front or rear value has to be
// fetched through the RAM read port. Front and rear values are also kept in
// registers, so no other command reads the RAM. A write to the capacity
// register empties the queue; it must only be done while no beat is in
// flight. Capacity 0 behaves as 1 and values above DEPTH saturate at DEPTH.
`include "circular_double_ended_queue_macros.svh"

module circular_double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0]  cfg_wdata,
	cdq_cmd_if.sink                    cmd,
	cdq_res_if.source                  res
);
	import cdq_pkg::*;

	localparam int AW          = $clog2(DEPTH);
	localparam int CW          = AW + 1;
	localparam int CAP_RST_EFF = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

	function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] v);
		if (v == '0) begin
			return CW'(1);
		end else if (32'(v) > 32'(DEPTH)) begin
			return CW'(DEPTH);
		end else begin
			return CW'(v);
		end
	endfunction

	state_t                state_q, state_next;
	logic [CW-1:0]         cap_q, count_q, count_d;
	logic [AW-1:0]         head_q, tail_q, head_d, tail_d;
	logic [AW-1:0]         head_inc, head_dec, tail_inc, tail_dec;
	logic [DATA_WIDTH-1:0] front_q, rear_q, front_d, rear_d, key_s, ram_rdata;
	logic                  pop_front_q;
	logic                  is_empty, is_full, rej_d, wr_d, need_rd, rd_front;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic                  in_acc, out_load;
	logic [DATA_WIDTH-1:0] res_front, res_rear;
	logic [CW-1:0]         res_count;
	logic                  res_rej;
	logic                  out_valid_q;
	logic [KEY_W-1:0]      out_front_q, out_rear_q;
	logic                  out_empty_q, out_full_q, out_rej_q;

	assign key_s    = DATA_WIDTH'(cmd.key);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == cap_q);

	assign head_dec = (head_q == '0) ? AW'(cap_q - CW'(1)) : head_q - AW'(1);
	assign tail_dec = (tail_q == '0) ? AW'(cap_q - CW'(1)) : tail_q - AW'(1);
	assign head_inc = ((CW'(head_q) + CW'(1)) >= cap_q) ? '0 : head_q + AW'(1);
	assign tail_inc = ((CW'(tail_q) + CW'(1)) >= cap_q) ? '0 : tail_q + AW'(1);

	// Effect of the offered command on the queue state.
	always_comb begin
		count_d  = count_q;
		head_d   = head_q;
		tail_d   = tail_q;
		front_d  = front_q;
		rear_d   = rear_q;
		rej_d    = 1'b0;
		wr_d     = 1'b0;
		wr_addr  = '0;
		need_rd  = 1'b0;
		rd_front = 1'b0;
		rd_addr  = '0;
		case (cmd.command) inside
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (is_full) begin
					rej_d = 1'b1;
				end else begin
					wr_d    = 1'b1;
					count_d = count_q + CW'(1);
					if (is_empty) begin
						head_d  = '0;
						tail_d  = '0;
						front_d = key_s;
						rear_d  = key_s;
					end else if (cmd.command == CMD_PUSH_FRONT) begin
						head_d  = head_dec;
						wr_addr = head_dec;
						front_d = key_s;
					end else begin
						tail_d  = tail_inc;
						wr_addr = tail_inc;
						rear_d  = key_s;
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (is_empty) begin
					rej_d = 1'b1;
				end else if (count_q == CW'(1)) begin
					count_d = '0;
					head_d  = '0;
					tail_d  = '0;
				end else begin
					count_d = count_q - CW'(1);
					need_rd = 1'b1;
					if (cmd.command == CMD_POP_FRONT) begin
						head_d   = head_inc;
						rd_addr  = head_inc;
						rd_front = 1'b1;
					end else begin
						tail_d  = tail_dec;
						rd_addr = tail_dec;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && need_rd) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State machine outputs.
	always_comb begin
		cmd.ready = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = !out_valid_q || res.ready;
				out_load  = cmd.valid && cmd.ready && !need_rd;
			end
			ST_READ: begin
				out_load = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign in_acc = cmd.valid && cmd.ready;

	// In the read state the indices and count are already updated; only the
	// fetched end value is new.
	always_comb begin
		if (state_q == ST_READ) begin
			res_front = pop_front_q ? ram_rdata : front_q;
			res_rear  = pop_front_q ? rear_q : ram_rdata;
			res_count = count_q;
			res_rej   = 1'b0;
		end else begin
			res_front = front_d;
			res_rear  = rear_d;
			res_count = count_d;
			res_rej   = rej_d;
		end
	end

	cdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (in_acc && wr_d),
		.waddr (wr_addr),
		.wdata (key_s),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CW'(CAP_RST_EFF);
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			pop_front_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				cap_q   <= eff_cap(cfg_wdata);
				count_q <= '0;
				head_q  <= '0;
				tail_q  <= '0;
			end else if (in_acc) begin
				count_q <= count_d;
				head_q  <= head_d;
				tail_q  <= tail_d;
			end
			if (in_acc) begin
				pop_front_q <= rd_front;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			front_q <= res_front;
			rear_q  <= res_rear;
		end else if (in_acc) begin
			front_q <= front_d;
			rear_q  <= rear_d;
		end
		if (out_load) begin
			out_front_q <= (res_count == '0) ? '1 : KEY_W'(signed'(res_front));
			out_rear_q  <= (res_count == '0) ? '1 : KEY_W'(signed'(res_rear));
			out_empty_q <= (res_count == '0);
			out_full_q  <= (res_count != '0) && (res_count == cap_q);
			out_rej_q   <= res_rej;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.front_value = signed'(out_front_q);
	assign res.rear_value  = signed'(out_rear_q);
	assign res.is_empty    = out_empty_q;
	assign res.is_full     = out_full_q;
	assign res.rejected    = out_rej_q;

	`CDQ_ASSERT_NEVER(a_count_over_cap, count_q > cap_q, "entry count exceeds capacity")
	`CDQ_ASSERT(a_index_in_range, (CW'(head_q) < cap_q) && (CW'(tail_q) < cap_q), "index out of range")
	`CDQ_ASSERT(a_reject_keeps_state, in_acc && rej_d && !cfg_we |=> $stable(count_q) && $stable(head_q) && $stable(tail_q), "rejected command changed the queue")
	`CDQ_ASSERT_NEVER(a_busy_output_in_read, (state_q == ST_READ) && out_valid_q, "result register occupied during fetch")
endmodule

// File: tb/testbench.sv
module testbench;
	import cdq_pkg::*;

	localparam int CMD_CODE_MAX   = (1 << CMD_W) - 1;
	localparam int STORE_DEPTH    = 16;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PERCENT   = 36;
	localparam int QUIET_LO       = 500;
	localparam int QUIET_HI       = 700;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 80;
	localparam int PHASE_ITEMS    = 120;

	localparam logic [KEY_W-1:0] KEY_MAX      = 32'h7fff_ffff;
	localparam logic [KEY_W-1:0] KEY_MIN      = 32'h8000_0000;
	localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED
	} burst_mode_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] front_value;
		logic signed [KEY_W-1:0] rear_value;
		logic                    is_empty;
		logic                    is_full;
		logic                    rejected;
	} deque_view_t;

	class deque_scoreboard;
		logic [KEY_W-1:0] store [STORE_DEPTH];
		logic [3:0]       head;
		logic [3:0]       tail;
		bit               empty;
		logic [CAP_W-1:0] capacity;
		deque_view_t      views [$];
		int               errors;

		function new();
			capacity = CAP_W'(CAP_RESET);
			empty = 1'b1;
			head = '0;
			tail = '0;
			errors = 0;
		endfunction

		function int unsigned wrap_point();
			int unsigned c;
			c = capacity;
			if (c == 0)
				c = 1;
			if (c > STORE_DEPTH)
				c = STORE_DEPTH;
			return c;
		endfunction

		function int unsigned entry_count();
			int unsigned cap;
			cap = wrap_point();
			if (empty)
				return 0;
			return ((tail + cap - head) % cap) + 1;
		endfunction

		function bit full_now();
			return entry_count() == wrap_point();
		endfunction

		function int outstanding();
			return views.size();
		endfunction

		// Writing the capacity also empties the queue.
		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
			empty = 1'b1;
			head = '0;
			tail = '0;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
			int unsigned cap;
			bit          rej;
			deque_view_t v;
			cap = wrap_point();
			rej = 1'b0;
			case (cmd)
				CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
					if (full_now()) begin
						rej = 1'b1;
					end else if (empty) begin
						head = '0;
						tail = '0;
						empty = 1'b0;
						store[0] = key;
					end else if (cmd == CMD_PUSH_FRONT) begin
						head = (head == 0) ? 4'(cap - 1) : head - 4'd1;
						store[head] = key;
					end else begin
						tail = (tail + 1 >= cap) ? 4'd0 : tail + 4'd1;
						store[tail] = key;
					end
				end
				CMD_POP_FRONT, CMD_POP_REAR: begin
					if (empty) begin
						rej = 1'b1;
					end else if (head == tail) begin
						// The last entry has gone: both indices return to the start.
						empty = 1'b1;
						head = '0;
						tail = '0;
					end else if (cmd == CMD_POP_FRONT) begin
						head = (head + 1 >= cap) ? 4'd0 : head + 4'd1;
					end else begin
						tail = (tail == 0) ? 4'(cap - 1) : tail - 4'd1;
					end
				end
				default: ;
			endcase
			v.is_empty = empty;
			v.front_value = empty ? KEY_ALL_ONES : store[head];
			v.rear_value = empty ? KEY_ALL_ONES : store[tail];
			v.is_full = full_now();
			v.rejected = rej;
			views.push_back(v);
		endfunction

		function void compare_view(deque_view_t got);
			deque_view_t want;
			if (views.size() == 0) begin
				$error("result beat with no command waiting: front_value %0d", got.front_value);
				errors++;
				return;
			end
			want = views.pop_front();
			if (got.front_value !== want.front_value) begin
				$error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
				errors++;
			end
			if (got.rear_value !== want.rear_value) begin
				$error("rear_value: expected %0d, got %0d", want.rear_value, got.rear_value);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
				errors++;
			end
			if (got.is_full !== want.is_full) begin
				$error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
				errors++;
			end
			if (got.rejected !== want.rejected) begin
				$error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	cdq_cmd_if cmd_bus ();
	cdq_res_if res_bus ();

	deque_scoreboard sb = new();
	int sent = 0;
	int stall = 0;

	circular_double_ended_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_bus),
		.res       (res_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] random_key();
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: return '0;
				1: return KEY_MAX;
				2: return KEY_MIN;
				default: return KEY_ALL_ONES;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [CMD_W-1:0] random_pop();
		return $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
	endfunction

	function automatic logic [CMD_W-1:0] random_command(burst_mode_t mode);
		int push_percent;
		if ($urandom_range(99) < 6)
			return CMD_W'($urandom_range(CMD_PEEK, CMD_CODE_MAX));
		case (mode)
			MODE_FILL:  push_percent = 75;
			MODE_DRAIN: push_percent = 25;
			default:    push_percent = 50;
		endcase
		if ($urandom_range(99) < push_percent)
			return $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
		return random_pop();
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k);
		if (!(sent >= QUIET_LO && sent < QUIET_HI)) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				cmd_bus.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.command <= c;
		cmd_bus.key <= k;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		sent++;
	endtask

	// Waits until every result has come back, so no delete is still fetching
	// through the RAM, then idles before returning.
	task automatic wait_drained();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(value);
	endtask

	task automatic empty_queue();
		int n;
		wait_drained();
		n = sb.entry_count();
		repeat (n) send_item(random_pop(), random_key());
		wait_drained();
	endtask

	task automatic run_phase(input logic [CAP_W-1:0] cap, input int items);
		int          done;
		int          len;
		burst_mode_t mode;
		write_capacity(cap);
		done = 0;
		while (done < items) begin
			mode = burst_mode_t'($urandom_range(MODE_MIXED));
			len = $urandom_range(4, 24);
			repeat (len) begin
				send_item(random_command(mode), random_key());
				done++;
			end
		end
		empty_queue();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.command <= CMD_PEEK;
		cmd_bus.key <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: empty queue, field extremes and the unused codes.
		send_item(CMD_PEEK, '0);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_POP_REAR, KEY_ALL_ONES);
		send_item(CMD_PUSH_FRONT, KEY_MAX);
		send_item(CMD_PUSH_REAR, KEY_MIN);
		send_item(CMD_PUSH_FRONT, '0);
		send_item(CMD_PUSH_REAR, KEY_ALL_ONES);
		for (int c = CMD_PEEK + 1; c <= CMD_CODE_MAX; c++)
			send_item(CMD_W'(c), KEY_MAX);
		send_item(CMD_PEEK, KEY_MIN);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_POP_REAR, '0);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_POP_REAR, '0);
		wait_drained();

		// A single entry: insert while full and delete while empty.
		write_capacity(1);
		send_item(CMD_PUSH_REAR, random_key());
		send_item(CMD_PUSH_FRONT, random_key());
		send_item(CMD_POP_REAR, '0);
		send_item(CMD_POP_FRONT, '0);
		wait_drained();

		// Two entries: the front index wraps to the last slot of the capacity.
		write_capacity(2);
		send_item(CMD_PUSH_FRONT, random_key());
		send_item(CMD_PUSH_FRONT, random_key());
		send_item(CMD_PUSH_REAR, random_key());
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_POP_REAR, '0);
		empty_queue();

		run_phase(16, PHASE_ITEMS);
		run_phase(3, PHASE_ITEMS);
		run_phase(0, PHASE_ITEMS);
		run_phase(31, PHASE_ITEMS);
		run_phase(17, PHASE_ITEMS);
		run_phase(5, PHASE_ITEMS);
		run_phase(CAP_W'($urandom_range(1, 31)), PHASE_ITEMS);
		run_phase(2, PHASE_ITEMS);
		run_phase(16, PHASE_ITEMS);

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side: random back-pressure, one quiet window and one long hold-off
	// that lets the block fill and stall its command input.
	initial begin
		int got;
		bit held;
		got = 0;
		held = 1'b0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
				got++;
			if (got >= HOLD_AT && !held) begin
				held = 1'b1;
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (got >= QUIET_LO && got < QUIET_HI) begin
				res_bus.ready <= 1'b1;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		deque_view_t seen;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) begin
				sb.note_command(cmd_bus.command, cmd_bus.key);
				moved = 1'b1;
			end
			if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
				seen.front_value = res_bus.front_value;
				seen.rear_value = res_bus.rear_value;
				seen.is_empty = res_bus.is_empty;
				seen.is_full = res_bus.is_full;
				seen.rejected = res_bus.rejected;
				sb.compare_view(seen);
				moved = 1'b1;
			end
			if (moved) begin
				stall = 0;
			end else begin
				stall++;
				if (stall >= WATCHDOG_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end
endmodule
